[rtl/qslerp_pkg.sv]
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, sideband type and helpers of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

  localparam int COMP_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int BLEND_W      = 15;
  localparam int FRAC_BITS    = 14;
  localparam int MARGIN_W     = 20;
  localparam int ANG_W        = 32;
  localparam int DOT_W        = 34;
  localparam int RAD_W        = 57;
  localparam int ROOT_W       = 29;
  localparam int NUM_W        = 49;
  localparam int REM_W        = 48;
  localparam int QUO_W        = 16;
  localparam int ADDR_W       = 3;

  localparam logic [ADDR_W-1:0]   ADDR_MARGIN  = 3'd0;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 20'd268;
  localparam logic [BLEND_W-1:0]  T_ONE        = 15'd16384;

  localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [ANG_W-1:0] GAIN_Q28    = 32'sd163008219;

  typedef struct packed {
    logic [3:0][COMP_BITS-1:0] f;
    logic [3:0][COMP_BITS-1:0] g;
    logic [3:0][COMP_BITS-1:0] lin;
    logic                      lin_flag;
    logic [BLEND_W-1:0]        blend;
    logic [ANG_W-1:0]          c;
    logic [ROOT_W-1:0]         s;
    logic [3:0]                neg;
    logic [3:0]                ovf;
  } side_t;

  // arctangent of 2^-step in Q.28
  function automatic logic signed [ANG_W-1:0] atan_q28(input int step);
    logic signed [ANG_W-1:0] a;
    case (step)
      0:       a = 32'sd210828714;
      1:       a = 32'sd124459457;
      2:       a = 32'sd65760959;
      3:       a = 32'sd33381290;
      4:       a = 32'sd16755422;
      5:       a = 32'sd8385879;
      6:       a = 32'sd4193963;
      7:       a = 32'sd2097109;
      8:       a = 32'sd1048571;
      9:       a = 32'sd524287;
      default: a = (step > 28) ? '0 : $signed(32'h1000_0000 >> step);
    endcase
    return a;
  endfunction

  function automatic logic [COMP_BITS-1:0] sat_comp(input logic signed [35:0] v);
    logic [COMP_BITS-1:0] r;
    if (v > 36'sd32767) r = 16'h7fff;
    else if (v < -36'sd32768) r = 16'h8000;
    else r = v[COMP_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/qslerp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One result bit of the pipelined integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire                                    clk,
  input  wire                                    en,
  input  wire  [qslerp_pkg::RAD_W-1:0]           rad_i,
  input  wire  [qslerp_pkg::ROOT_W-1:0]          root_i,
  input  wire  qslerp_pkg::side_t                side_i,
  output logic [qslerp_pkg::RAD_W-1:0]           rad_o,
  output logic [qslerp_pkg::ROOT_W-1:0]          root_o,
  output qslerp_pkg::side_t                      side_o
);

  logic [59:0]                         trial;
  logic [qslerp_pkg::RAD_W-1:0]        rad_nxt, rad_r;
  logic [qslerp_pkg::ROOT_W-1:0]       root_nxt, root_r;
  qslerp_pkg::side_t                   side_r;

  always_comb begin
    trial    = (60'(root_i) << (BIT + 1)) + (60'd1 << (2 * BIT));
    rad_nxt  = rad_i;
    root_nxt = root_i;
    if (60'(rad_i) >= trial) begin
      rad_nxt       = rad_i - trial[qslerp_pkg::RAD_W-1:0];
      root_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[rtl/qslerp_vec_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_vec_cell
// One vectoring CORDIC step: drive y toward zero, accumulate the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_vec_cell #(
  parameter int STEP = 0
) (
  input  wire                                        clk,
  input  wire                                        en,
  input  wire  signed [qslerp_pkg::ANG_W-1:0]        x_i,
  input  wire  signed [qslerp_pkg::ANG_W-1:0]        y_i,
  input  wire  signed [qslerp_pkg::ANG_W-1:0]        z_i,
  input  wire  qslerp_pkg::side_t                    side_i,
  output logic signed [qslerp_pkg::ANG_W-1:0]        x_o,
  output logic signed [qslerp_pkg::ANG_W-1:0]        y_o,
  output logic signed [qslerp_pkg::ANG_W-1:0]        z_o,
  output qslerp_pkg::side_t                          side_o
);

  localparam logic signed [qslerp_pkg::ANG_W-1:0] ATAN = qslerp_pkg::atan_q28(STEP);

  logic signed [qslerp_pkg::ANG_W-1:0] x_nxt, y_nxt, z_nxt, x_r, y_r, z_r;
  qslerp_pkg::side_t                   side_r;

  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> STEP);
      y_nxt = y_i - (x_i >>> STEP);
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - (y_i >>> STEP);
      y_nxt = y_i + (x_i >>> STEP);
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[rtl/qslerp_rot_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_rot_cell
// One rotation CORDIC step for the pair of partial angles.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_rot_cell #(
  parameter int STEP = 0
) (
  input  wire                                         clk,
  input  wire                                         en,
  input  wire  [1:0][qslerp_pkg::ANG_W-1:0]           x_i,
  input  wire  [1:0][qslerp_pkg::ANG_W-1:0]           y_i,
  input  wire  [1:0][qslerp_pkg::ANG_W-1:0]           th_i,
  input  wire  qslerp_pkg::side_t                     side_i,
  output logic [1:0][qslerp_pkg::ANG_W-1:0]           x_o,
  output logic [1:0][qslerp_pkg::ANG_W-1:0]           y_o,
  output logic [1:0][qslerp_pkg::ANG_W-1:0]           th_o,
  output qslerp_pkg::side_t                           side_o
);

  localparam logic signed [qslerp_pkg::ANG_W-1:0] ATAN = qslerp_pkg::atan_q28(STEP);

  logic [1:0][qslerp_pkg::ANG_W-1:0] x_nxt, y_nxt, th_nxt, x_r, y_r, th_r;
  qslerp_pkg::side_t                 side_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (!th_i[k][qslerp_pkg::ANG_W-1]) begin
        x_nxt[k]  = $signed(x_i[k]) - ($signed(y_i[k]) >>> STEP);
        y_nxt[k]  = $signed(y_i[k]) + ($signed(x_i[k]) >>> STEP);
        th_nxt[k] = $signed(th_i[k]) - ATAN;
      end else begin
        x_nxt[k]  = $signed(x_i[k]) + ($signed(y_i[k]) >>> STEP);
        y_nxt[k]  = $signed(y_i[k]) - ($signed(x_i[k]) >>> STEP);
        th_nxt[k] = $signed(th_i[k]) + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      th_r   <= th_nxt;
      side_r <= side_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign th_o   = th_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[rtl/qslerp_div_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One quotient bit of the restoring divide, four components side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_div_cell #(
  parameter int BIT = 0
) (
  input  wire                                     clk,
  input  wire                                     en,
  input  wire  [3:0][qslerp_pkg::REM_W-1:0]       rem_i,
  input  wire  [3:0][qslerp_pkg::QUO_W-1:0]       q_i,
  input  wire  qslerp_pkg::side_t                 side_i,
  output logic [3:0][qslerp_pkg::REM_W-1:0]       rem_o,
  output logic [3:0][qslerp_pkg::QUO_W-1:0]       q_o,
  output qslerp_pkg::side_t                       side_o
);

  logic [qslerp_pkg::REM_W-1:0]       dsh;
  logic [3:0][qslerp_pkg::REM_W-1:0]  rem_nxt, rem_r;
  logic [3:0][qslerp_pkg::QUO_W-1:0]  q_nxt, q_r;
  qslerp_pkg::side_t                  side_r;

  always_comb begin
    dsh     = qslerp_pkg::REM_W'(side_i.s) << BIT;
    rem_nxt = rem_i;
    q_nxt   = q_i;
    for (int k = 0; k < 4; k++) begin
      if (rem_i[k] >= dsh) begin
        rem_nxt[k]    = rem_i[k] - dsh;
        q_nxt[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[rtl/quaternion_slerp.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one beat carries from_x..from_w, to_x..to_w (Q2.14) and
//   blend (Q.14); out_* channel: one beat per input beat with the four
//   interpolated components in tdata and linear_used in tuser.
//   cfg_* APB port: near_one_margin at byte address 0 (Q.28 units).
// Datapath: a row of registered cells: 29 square-root cells, CORDIC_STEPS
//   vectoring cells, CORDIC_STEPS rotation cells and 16 divide cells, plus
//   the S1, S2, S3, W, M, F, N and D0 registers and the output register.
// Throughput: one beat per cycle while the output is not held.
// Stall: the whole row advances only when the output register is empty or
//   being taken; in_tready follows that, so a held result holds the row.
// Reset: clears all valid bits and restores the margin to 268.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp #(
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS
) (
  input  wire          clk,
  input  wire          rst_n,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, blend, pad
  input  wire  [143:0] in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // out_x, out_y, out_z, out_w
  output logic [63:0]  out_tdata,
  // linear_used
  output logic [0:0]   out_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [qslerp_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int LAT = 54 + 2 * CORDIC_STEPS;
  localparam int CB  = qslerp_pkg::COMP_BITS;
  localparam int AW  = qslerp_pkg::ANG_W;

  logic                             adv;
  logic [LAT-1:0]                   vld_r;
  logic [qslerp_pkg::MARGIN_W-1:0]  margin_r;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == qslerp_pkg::ADDR_MARGIN) ? 32'(margin_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= qslerp_pkg::MARGIN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == qslerp_pkg::ADDR_MARGIN) begin
      margin_r <= cfg_pwdata[qslerp_pkg::MARGIN_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------- S1: dot product and linear blend ----------------
  qslerp_pkg::side_t                 s1_side_nxt, s1_side_r;
  logic signed [qslerp_pkg::DOT_W-1:0] s1_c_nxt, s1_c_r;
  logic [qslerp_pkg::BLEND_W-1:0]    t_cl, t_inv;
  logic signed [31:0]                pd   [4];
  logic signed [31:0]                pa   [4];
  logic signed [31:0]                pb   [4];
  logic signed [33:0]                lv   [4];

  always_comb begin
    s1_side_nxt = '0;
    t_cl  = (in_tdata[142:128] > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : in_tdata[142:128];
    t_inv = qslerp_pkg::T_ONE - t_cl;
    s1_side_nxt.blend = t_cl;
    s1_c_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      s1_side_nxt.f[k] = in_tdata[CB*k +: CB];
      s1_side_nxt.g[k] = in_tdata[CB*(k+4) +: CB];
      pd[k] = $signed(in_tdata[CB*k +: CB]) * $signed(in_tdata[CB*(k+4) +: CB]);
      pa[k] = $signed(in_tdata[CB*k +: CB]) * $signed({1'b0, t_inv});
      pb[k] = $signed(in_tdata[CB*(k+4) +: CB]) * $signed({1'b0, t_cl});
      lv[k] = 34'(pa[k]) + 34'(pb[k]) + 34'sd8192;
      s1_side_nxt.lin[k] = qslerp_pkg::sat_comp(36'(lv[k] >>> qslerp_pkg::FRAC_BITS));
      s1_c_nxt = s1_c_nxt + 34'(pd[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      s1_c_r    <= s1_c_nxt;
    end
  end

  // ---------------- S2: range check ----------------
  qslerp_pkg::side_t  s2_side_nxt, s2_side_r;
  logic signed [34:0] lo_b, hi_b, c35;
  logic [33:0]        c_abs;
  logic [27:0]        s2_cu_r;

  always_comb begin
    c35  = 35'(s1_c_r);
    lo_b = -35'sd268435456 + $signed(35'(margin_r));
    hi_b =  35'sd268435456 - $signed(35'(margin_r));
    c_abs = s1_c_r[qslerp_pkg::DOT_W-1] ? 34'(-s1_c_r) : 34'(s1_c_r);
    s2_side_nxt          = s1_side_r;
    s2_side_nxt.lin_flag = !((lo_b < c35) && (c35 < hi_b));
    s2_side_nxt.c        = s1_c_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s2_side_nxt;
      s2_cu_r   <= c_abs[27:0];
    end
  end

  // ---------------- S3: radicand ----------------
  qslerp_pkg::side_t              s3_side_r;
  logic [qslerp_pkg::RAD_W-1:0]   s3_rad_r;
  logic [55:0]                    cu_sq;

  assign cu_sq = s2_cu_r * s2_cu_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r <= s2_side_r;
      s3_rad_r  <= {1'b1, 56'd0} - {1'b0, cu_sq};
    end
  end

  // ---------------- square root row ----------------
  localparam int NSQ = qslerp_pkg::ROOT_W;
  logic [qslerp_pkg::RAD_W-1:0]  sq_rad  [NSQ+1];
  logic [qslerp_pkg::ROOT_W-1:0] sq_root [NSQ+1];
  qslerp_pkg::side_t             sq_side [NSQ+1];

  assign sq_rad[0]  = s3_rad_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    qslerp_sqrt_cell #(.BIT(NSQ - 1 - i)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rad_i  (sq_rad[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .rad_o  (sq_rad[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // ---------------- vectoring CORDIC row: acos ----------------
  logic signed [AW-1:0]   vx [CORDIC_STEPS+1];
  logic signed [AW-1:0]   vy [CORDIC_STEPS+1];
  logic signed [AW-1:0]   vz [CORDIC_STEPS+1];
  qslerp_pkg::side_t      vside [CORDIC_STEPS+1];
  qslerp_pkg::side_t      v0_side;
  logic [qslerp_pkg::ROOT_W-1:0] s_val;

  always_comb begin
    s_val      = (sq_root[NSQ] == '0) ? qslerp_pkg::ROOT_W'(1) : sq_root[NSQ];
    v0_side    = sq_side[NSQ];
    v0_side.s  = s_val;
  end

  assign vside[0] = v0_side;
  assign vx[0] = $signed(AW'(s_val));
  assign vy[0] = $signed(sq_side[NSQ].c);
  assign vz[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    qslerp_vec_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .en     (adv),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .side_i (vside[i]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .side_o (vside[i+1])
    );
  end

  // ---------------- W: omega, clamped to [0, pi] ----------------
  qslerp_pkg::side_t  w_side_r;
  logic signed [32:0] w_raw;
  logic [29:0]        w_nxt, w_r;

  always_comb begin
    w_raw = 33'(qslerp_pkg::HALF_PI_Q28) - 33'(vz[CORDIC_STEPS]);
    if (w_raw < 0) w_nxt = '0;
    else if (w_raw > 33'(qslerp_pkg::PI_Q28)) w_nxt = 30'(qslerp_pkg::PI_Q28);
    else w_nxt = w_raw[29:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_side_r <= vside[CORDIC_STEPS];
      w_r      <= w_nxt;
    end
  end

  // ---------------- M: partial angles ----------------
  qslerp_pkg::side_t  m_side_r;
  logic [45:0]        ma, mb;
  logic [29:0]        ta_r, tb_r;

  always_comb begin
    ma = 46'(w_r) * 46'(qslerp_pkg::T_ONE - w_side_r.blend) + 46'd8192;
    mb = 46'(w_r) * 46'(w_side_r.blend) + 46'd8192;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side_r <= w_side_r;
      ta_r     <= ma[43:14];
      tb_r     <= mb[43:14];
    end
  end

  // ---------------- F: fold above pi/2 ----------------
  qslerp_pkg::side_t    f_side_r;
  logic [1:0][AW-1:0]   fth_nxt, fth_r;

  always_comb begin
    fth_nxt[0] = ($signed(AW'(ta_r)) > qslerp_pkg::HALF_PI_Q28) ?
                 qslerp_pkg::PI_Q28 - $signed(AW'(ta_r)) : AW'(ta_r);
    fth_nxt[1] = ($signed(AW'(tb_r)) > qslerp_pkg::HALF_PI_Q28) ?
                 qslerp_pkg::PI_Q28 - $signed(AW'(tb_r)) : AW'(tb_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r <= m_side_r;
      fth_r    <= fth_nxt;
    end
  end

  // ---------------- rotation CORDIC row: two sines ----------------
  logic [1:0][AW-1:0]   rx  [CORDIC_STEPS+1];
  logic [1:0][AW-1:0]   ry  [CORDIC_STEPS+1];
  logic [1:0][AW-1:0]   rth [CORDIC_STEPS+1];
  qslerp_pkg::side_t    rside [CORDIC_STEPS+1];

  assign rx[0]    = {qslerp_pkg::GAIN_Q28, qslerp_pkg::GAIN_Q28};
  assign ry[0]    = '0;
  assign rth[0]   = fth_r;
  assign rside[0] = f_side_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    qslerp_rot_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .en     (adv),
      .x_i    (rx[i]),
      .y_i    (ry[i]),
      .th_i   (rth[i]),
      .side_i (rside[i]),
      .x_o    (rx[i+1]),
      .y_o    (ry[i+1]),
      .th_o   (rth[i+1]),
      .side_o (rside[i+1])
    );
  end

  // ---------------- N: numerators ----------------
  qslerp_pkg::side_t                      n_side_r;
  logic signed [47:0]                     na [4];
  logic signed [47:0]                     nb [4];
  logic [3:0][qslerp_pkg::NUM_W-1:0]      num_nxt, num_r;

  function automatic logic [CB-1:0] n_in_f(input int k);
    return rside[CORDIC_STEPS].f[k];
  endfunction

  function automatic logic [CB-1:0] n_in_g(input int k);
    return rside[CORDIC_STEPS].g[k];
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      na[k] = $signed(n_in_f(k)) * $signed(ry[CORDIC_STEPS][0]);
      nb[k] = $signed(n_in_g(k)) * $signed(ry[CORDIC_STEPS][1]);
      num_nxt[k] = 49'(na[k]) + 49'(nb[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_side_r <= rside[CORDIC_STEPS];
      num_r    <= num_nxt;
    end
  end

  // ---------------- D0: magnitude, sign, overflow ----------------
  qslerp_pkg::side_t                  d0_side_nxt, d0_side_r;
  logic [3:0][qslerp_pkg::REM_W-1:0]  d0_rem_nxt, d0_rem_r;
  logic [qslerp_pkg::NUM_W-1:0]       mag;
  logic [qslerp_pkg::NUM_W-1:0]       lim;

  always_comb begin
    d0_side_nxt = n_side_r;
    lim = qslerp_pkg::NUM_W'(n_side_r.s) << qslerp_pkg::QUO_W;
    for (int k = 0; k < 4; k++) begin
      d0_side_nxt.neg[k] = num_r[k][qslerp_pkg::NUM_W-1];
      mag = num_r[k][qslerp_pkg::NUM_W-1] ? 49'(-$signed(num_r[k])) : num_r[k];
      d0_side_nxt.ovf[k] = (mag >= lim);
      d0_rem_nxt[k] = mag[qslerp_pkg::REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_side_r <= d0_side_nxt;
      d0_rem_r  <= d0_rem_nxt;
    end
  end

  // ---------------- divide row ----------------
  localparam int NQ = qslerp_pkg::QUO_W;
  logic [3:0][qslerp_pkg::REM_W-1:0] dv_rem [NQ+1];
  logic [3:0][qslerp_pkg::QUO_W-1:0] dv_q   [NQ+1];
  qslerp_pkg::side_t                 dv_side[NQ+1];

  assign dv_rem[0]  = d0_rem_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = d0_side_r;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    qslerp_div_cell #(.BIT(NQ - 1 - i)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .side_i (dv_side[i]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // ---------------- output stage: sign, saturate, pick branch ----------------
  qslerp_pkg::side_t      os;
  logic [3:0][CB-1:0]     res_nxt, res_r;
  logic                   flag_r;
  logic [CB-1:0]          q;

  always_comb begin
    os = dv_side[NQ];
    for (int k = 0; k < 4; k++) begin
      q = dv_q[NQ][k];
      if (os.lin_flag) res_nxt[k] = os.lin[k];
      else if (os.ovf[k]) res_nxt[k] = os.neg[k] ? 16'h8000 : 16'h7fff;
      else if (os.neg[k]) res_nxt[k] = (q > 16'd32768) ? 16'h8000 : 16'(17'd0 - {1'b0, q});
      else res_nxt[k] = (q > 16'd32767) ? 16'h7fff : q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= res_nxt;
      flag_r <= os.lin_flag;
    end
  end

  assign out_tdata = res_r;
  assign out_tuser = flag_r;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp testbench
// Drives quaternion pairs with blend factors through the stream port,
// predicts every result with a bit-exact fixed-point model (dot product,
// square root, CORDIC arc cosine and sine, divide or linear blend) and
// checks each output beat in order, under several margin settings and
// several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------

class slerp_scoreboard;
  typedef struct packed {
    logic [63:0] comp;
    logic        lin;
  } slerp_res_t;

  slerp_res_t       expected_q[$];
  logic [19:0]      margin;
  int               errors;

  function new();
    margin = qslerp_pkg::MARGIN_RESET;
    errors = 0;
  endfunction

  static function longint atan_step(int i);
    longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                        8385879, 4193963, 2097109, 1048571, 524287};
    if (i < 10) return tbl[i];
    return longint'(1 << 28) >>> i;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // angle from the cosine axis by vectoring
  static function longint arc_cosine(longint c, longint s);
    longint x, y, z, dx, dy, w;
    x = s; y = c; z = 0;
    for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    w = 421657428 - z;
    if (w < 0) w = 0;
    if (w > 843314857) w = 843314857;
    return w;
  endfunction

  static function longint sine_q28(longint th);
    longint x, y, dx, dy;
    x = 163008219; y = 0;
    if (th > 421657428) th = 843314857 - th;
    for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (th >= 0) begin
        x -= dx; y += dy; th -= atan_step(i);
      end else begin
        x += dx; y -= dy; th += atan_step(i);
      end
    end
    return y;
  endfunction

  static function logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function slerp_res_t interpolate(logic [143:0] beat);
    slerp_res_t r;
    longint f[4], g[4];
    longint c, t, lo, hi, s, w, sa, sb, num, v;
    longint unsigned cu;
    c = 0;
    for (int k = 0; k < 4; k++) begin
      f[k] = longint'($signed(beat[16*k +: 16]));
      g[k] = longint'($signed(beat[64 + 16*k +: 16]));
      c += f[k] * g[k];
    end
    t = longint'(beat[142:128]);
    if (t > 16384) t = 16384;
    lo = -(longint'(1) << 28) + longint'(margin);
    hi = (longint'(1) << 28) - longint'(margin);
    if (lo < c && c < hi) begin
      cu = (c < 0) ? -c : c;
      s = int_sqrt((64'd1 << 56) - cu * cu);
      if (s < 1) s = 1;
      w = arc_cosine(c, s);
      sa = sine_q28((w * (16384 - t) + 8192) >>> 14);
      sb = sine_q28((w * t + 8192) >>> 14);
      for (int k = 0; k < 4; k++) begin
        num = f[k] * sa + g[k] * sb;
        r.comp[16*k +: 16] = clip16(num / s);
      end
      r.lin = 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        v = f[k] * (16384 - t) + g[k] * t + 8192;
        r.comp[16*k +: 16] = clip16(v >>> 14);
      end
      r.lin = 1'b1;
    end
    return r;
  endfunction

  function void note_input(logic [143:0] beat);
    expected_q.push_back(interpolate(beat));
  endfunction

  function void check_result(logic [63:0] data, logic lin);
    slerp_res_t e;
    string names[4] = '{"out_x", "out_y", "out_z", "out_w"};
    if (expected_q.size() == 0) begin
      $error("unexpected result beat %h", data);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    for (int k = 0; k < 4; k++)
      if (data[16*k +: 16] !== e.comp[16*k +: 16]) begin
        $error("%s: expected %0d, got %0d", names[k],
               $signed(e.comp[16*k +: 16]), $signed(data[16*k +: 16]));
        errors++;
      end
    if (lin !== e.lin) begin
      $error("linear_used: expected %0d, got %0d", e.lin, lin);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [143:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [qslerp_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  slerp_scoreboard sb = new();
  int send_idle_pct = 7;
  int recv_idle_pct = 50;

  quaternion_slerp dut (
    .clk, .rst_n,
    .in_tdata, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [143:0] pack_beat(logic [15:0] fx, fy, fz, fw,
                                             logic [15:0] tx, ty, tz, tw,
                                             logic [14:0] bl);
    return {1'b0, bl, tw, tz, ty, tx, fw, fz, fy, fx};
  endfunction

  function automatic logic [15:0] rand_comp(int span);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic send_beat(logic [143:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = beat;
    do @(posedge clk); while (!in_tready);
    sb.note_input(beat);
    @(negedge clk);
  endtask

  task automatic write_margin(logic [19:0] value);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = qslerp_pkg::ADDR_MARGIN;
    cfg_pwdata = 32'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.margin = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // hold off the sender until the pipe is empty
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] f[4], g[4];
    logic [14:0] bl;
    int kind, span;
    kind = $urandom_range(99);
    span = $urandom_range(8192);
    for (int k = 0; k < 4; k++) begin
      if (kind < 60) begin
        f[k] = rand_comp(span);
        g[k] = rand_comp(span);
      end else if (kind < 75) begin
        // near parallel or antiparallel pair
        f[k] = rand_comp(8192);
        g[k] = f[k] + rand_comp($urandom_range(1) ? 0 : 4);
      end else if (kind < 90) begin
        f[k] = rand_comp(16384);
        g[k] = rand_comp(16384);
      end else begin
        f[k] = 16'($urandom);
        g[k] = 16'($urandom);
      end
    end
    if (kind >= 60 && kind < 75 && $urandom_range(1))
      for (int k = 0; k < 4; k++) g[k] = -g[k];
    bl = ($urandom_range(99) < 85) ? 15'($urandom_range(16384)) : 15'($urandom);
    send_beat(pack_beat(f[0], f[1], f[2], f[3], g[0], g[1], g[2], g[3], bl));
  endtask

  // result side: stall at random, check each beat
  initial begin
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    end
  end

  initial begin
    logic [19:0] margins[6];
    margins = '{qslerp_pkg::MARGIN_RESET, 20'd0, 20'hfffff, 20'($urandom),
                20'($urandom_range(4096)), qslerp_pkg::MARGIN_RESET};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed beats
    send_beat(pack_beat(0, 0, 0, 16384, 0, 0, 0, 16384, 8192));
    send_beat(pack_beat(0, 0, 0, 16384, 0, 0, 0, -16384, 8192));
    send_beat(pack_beat(0, 0, 0, 16384, 16384, 0, 0, 0, 0));
    send_beat(pack_beat(0, 0, 0, 16384, 16384, 0, 0, 0, 16384));
    send_beat(pack_beat(0, 0, 0, 16384, 16384, 0, 0, 0, 8192));
    send_beat(pack_beat(0, 0, 0, 16384, 16384, 0, 0, 0, 15'h7fff));
    send_beat(pack_beat(0, 0, 0, 16384, 16384, 0, 0, 0, 16385));
    send_beat(pack_beat(11585, 0, 0, 11585, 0, 11585, 11585, 0, 4096));
    send_beat(pack_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000, 8192));
    send_beat(pack_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000, 3000));
    send_beat(pack_beat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                        16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16384));
    send_beat(pack_beat(-16384, -16384, -16384, -16384,
                        16384, 16384, 16384, 16384, 12000));
    // cosine exactly at the upper and lower bound, either side of the upper one, inside the lower one
    send_beat(pack_beat(16384, 4, 0, 0, 16383, 4029, 0, 0, 5000));
    send_beat(pack_beat(16384, 4, 0, 0, -16383, -4029, 0, 0, 5000));
    send_beat(pack_beat(16384, 4, 0, 0, 16383, 4030, 0, 0, 5000));
    send_beat(pack_beat(16384, 4, 0, 0, 16383, 4028, 0, 0, 5000));
    send_beat(pack_beat(16384, 4, 0, 0, -16383, -4028, 0, 0, 5000));
    // small angle and zero quaternion
    send_beat(pack_beat(0, 0, 16, 16384, 0, 0, -16, 16384, 8000));
    send_beat(pack_beat(0, 0, 0, 0, 0, 0, 0, 0, 9000));
    send_beat(pack_beat(100, -200, 300, -400, 500, 600, -700, 800, 1));

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p > 0) write_margin(margins[p]);
      send_idle_pct = (p % 3 == 1) ? 50 : ((p % 3 == 0) ? 7 : 0);
      recv_idle_pct = (p % 3 == 0) ? 50 : ((p % 3 == 1) ? 7 : 0);
      for (int n = 0; n < 225; n++) send_random();
    end
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
